FILE: rtl/tekd_pkg.sv
package tekd_pkg;

    // field widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned KEY_W     = 11;
    localparam int unsigned TICK_W    = 16;
    localparam int unsigned APB_DW    = 32;
    localparam int unsigned APB_AW    = 3;

    // command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // register index (word address bit)
    localparam logic REG_TIMEOUT = 1'b0;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd50;
    localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

    // special bytes
    localparam logic [BYTE_W-1:0] BYTE_ESC   = 8'd27;
    localparam logic [BYTE_W-1:0] BYTE_CSI   = 8'h5B; // '['
    localparam logic [BYTE_W-1:0] BYTE_SS3   = 8'h4F; // 'O'
    localparam logic [BYTE_W-1:0] BYTE_TILDE = 8'h7E; // '~'

    // key codes
    localparam logic [KEY_W-1:0] KEY_ESC   = 11'd27;
    localparam logic [KEY_W-1:0] KEY_UP    = 11'd1001;
    localparam logic [KEY_W-1:0] KEY_DOWN  = 11'd1002;
    localparam logic [KEY_W-1:0] KEY_LEFT  = 11'd1003;
    localparam logic [KEY_W-1:0] KEY_RIGHT = 11'd1004;
    localparam logic [KEY_W-1:0] KEY_HOME  = 11'd1010;
    localparam logic [KEY_W-1:0] KEY_END   = 11'd1011;
    localparam logic [KEY_W-1:0] KEY_PGUP  = 11'd1012;
    localparam logic [KEY_W-1:0] KEY_PGDN  = 11'd1013;
    localparam logic [KEY_W-1:0] KEY_DEL   = 11'd1014;
    localparam logic [KEY_W-1:0] KEY_F1    = 11'd1101;
    localparam logic [KEY_W-1:0] KEY_F2    = 11'd1102;
    localparam logic [KEY_W-1:0] KEY_F3    = 11'd1103;
    localparam logic [KEY_W-1:0] KEY_F4    = 11'd1104;
    localparam logic [KEY_W-1:0] KEY_F5    = 11'd1105;
    localparam logic [KEY_W-1:0] KEY_F6    = 11'd1106;
    localparam logic [KEY_W-1:0] KEY_F7    = 11'd1107;
    localparam logic [KEY_W-1:0] KEY_F8    = 11'd1108;
    localparam logic [KEY_W-1:0] KEY_F9    = 11'd1109;
    localparam logic [KEY_W-1:0] KEY_F10   = 11'd1110;
    localparam logic [KEY_W-1:0] KEY_F11   = 11'd1111;
    localparam logic [KEY_W-1:0] KEY_F12   = 11'd1112;
    localparam logic [KEY_W-1:0] KEY_MAX   = KEY_F12;

    // parser phase, one-hot
    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_ESC  = 6'b000010,
        PH_CSI  = 6'b000100,
        PH_SS3  = 6'b001000,
        PH_NUM1 = 6'b010000,
        PH_NUM2 = 6'b100000
    } phase_t;

    function automatic logic is_digit(input logic [BYTE_W-1:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic [KEY_W-1:0] raw_key(input logic [BYTE_W-1:0] b);
        return {{(KEY_W-BYTE_W){1'b0}}, b};
    endfunction

    // final byte after ESC [
    function automatic logic [KEY_W-1:0] csi_final(input logic [BYTE_W-1:0] b);
        logic [KEY_W-1:0] k;
        case (b)
            8'h41:   k = KEY_UP;    // 'A'
            8'h42:   k = KEY_DOWN;  // 'B'
            8'h43:   k = KEY_RIGHT; // 'C'
            8'h44:   k = KEY_LEFT;  // 'D'
            8'h48:   k = KEY_HOME;  // 'H'
            8'h46:   k = KEY_END;   // 'F'
            default: k = raw_key(b);
        endcase
        return k;
    endfunction

    // final byte after ESC O
    function automatic logic [KEY_W-1:0] ss3_final(input logic [BYTE_W-1:0] b);
        logic [KEY_W-1:0] k;
        case (b)
            8'h50:   k = KEY_F1;   // 'P'
            8'h51:   k = KEY_F2;   // 'Q'
            8'h52:   k = KEY_F3;   // 'R'
            8'h53:   k = KEY_F4;   // 'S'
            8'h48:   k = KEY_HOME; // 'H'
            8'h46:   k = KEY_END;  // 'F'
            default: k = raw_key(b);
        endcase
        return k;
    endfunction

    // ESC [ d ~
    function automatic logic [KEY_W-1:0] one_digit_key(input logic [BYTE_W-1:0] d);
        logic [KEY_W-1:0] k;
        case (d)
            8'h31, 8'h37: k = KEY_HOME;
            8'h33:        k = KEY_DEL;
            8'h34, 8'h38: k = KEY_END;
            8'h35:        k = KEY_PGUP;
            8'h36:        k = KEY_PGDN;
            default:      k = raw_key(d);
        endcase
        return k;
    endfunction

    // ESC [ d d ~
    function automatic logic [KEY_W-1:0] two_digit_key(input logic [BYTE_W-1:0] d1,
                                                       input logic [BYTE_W-1:0] d2);
        logic [KEY_W-1:0] k;
        k = raw_key(d1);
        if (d1 == 8'h31) begin
            case (d2)
                8'h35:   k = KEY_F5;
                8'h37:   k = KEY_F6;
                8'h38:   k = KEY_F7;
                8'h39:   k = KEY_F8;
                default: k = raw_key(d1);
            endcase
        end else if (d1 == 8'h32) begin
            case (d2)
                8'h30:   k = KEY_F9;
                8'h31:   k = KEY_F10;
                8'h33:   k = KEY_F11;
                8'h34:   k = KEY_F12;
                default: k = raw_key(d1);
            endcase
        end
        return k;
    endfunction

endpackage

FILE: rtl/terminal_escape_key_decoder_unit.sv
// terminal escape key decoder: bytes and ticks in, key codes out
// path from input request to result valid: input register, then result register
// one input request per cycle unless a result stalls; one state transition per request
// a stalled result holds; the input register still takes a request when it drains
// reset (rst_n low, asynchronous): parser idle, digits and tick count zero, timeout 50
module terminal_escape_key_decoder_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic [tekd_pkg::BYTE_W-1:0]   byte_value,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tekd_pkg::KEY_W-1:0]    key_code,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tekd_pkg::APB_AW-1:0]   paddr,
    input  logic [tekd_pkg::APB_DW-1:0]   pwdata,
    output logic [tekd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    import tekd_pkg::*;

    // configuration register
    logic [TICK_W-1:0] timeout_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr && (paddr[2] == REG_TIMEOUT))
        begin
            timeout_reg <= pwdata[TICK_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_TIMEOUT)
            prdata = {{(APB_DW-TICK_W){1'b0}}, timeout_reg};
        else
            prdata = '0;
    end

    // input register
    logic              s1_valid_reg;
    logic              s1_cmd_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_fire;
    logic              in_fire;
    logic              out_free;

    assign out_free = !out_valid || out_ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg  <= command;
            s1_byte_reg <= byte_value;
        end
    end

    // parser state
    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] d1_reg, d1_next;
    logic [BYTE_W-1:0] d2_reg, d2_next;
    logic [TICK_W-1:0] count_reg, count_next;
    logic [TICK_W-1:0] count_inc;
    logic              emit;
    logic [KEY_W-1:0]  code;
    logic              pending;
    logic              in_number;

    assign pending   = (phase_reg == PH_ESC) || (phase_reg == PH_CSI) ||
                       (phase_reg == PH_SS3) || (phase_reg == PH_NUM1) ||
                       (phase_reg == PH_NUM2);
    assign in_number = (phase_reg == PH_NUM1) || (phase_reg == PH_NUM2);
    assign count_inc = (count_reg < TICK_MAX) ? count_reg + 1'b1 : count_reg;

    // one transition per request
    always_comb
    begin
        phase_next = phase_reg;
        d1_next    = d1_reg;
        d2_next    = d2_reg;
        count_next = count_reg;
        emit       = 1'b0;
        code       = '0;

        if (s1_cmd_reg == CMD_TICK)
        begin
            if (!pending)
            begin
                phase_next = PH_IDLE;
                count_next = '0;
            end
            else
            begin
                count_next = count_inc;
                if (count_inc >= timeout_reg)
                begin
                    emit = 1'b1;
                    code = in_number ? raw_key(d1_reg) : KEY_ESC;
                end
            end
        end
        else
        begin
            count_next = '0;
            unique case (phase_reg)
                PH_ESC:
                begin
                    if (s1_byte_reg == BYTE_CSI)
                        phase_next = PH_CSI;
                    else if (s1_byte_reg == BYTE_SS3)
                        phase_next = PH_SS3;
                    else
                    begin
                        emit = 1'b1;
                        code = KEY_ESC;
                    end
                end
                PH_CSI:
                begin
                    if (is_digit(s1_byte_reg))
                    begin
                        d1_next    = s1_byte_reg;
                        phase_next = PH_NUM1;
                    end
                    else
                    begin
                        emit = 1'b1;
                        code = csi_final(s1_byte_reg);
                    end
                end
                PH_SS3:
                begin
                    emit = 1'b1;
                    code = ss3_final(s1_byte_reg);
                end
                PH_NUM1:
                begin
                    if (s1_byte_reg == BYTE_TILDE)
                    begin
                        emit = 1'b1;
                        code = one_digit_key(d1_reg);
                    end
                    else if (is_digit(s1_byte_reg) && ((d1_reg == 8'h31) || (d1_reg == 8'h32)))
                    begin
                        d2_next    = s1_byte_reg;
                        phase_next = PH_NUM2;
                    end
                    else
                    begin
                        emit = 1'b1;
                        code = raw_key(d1_reg);
                    end
                end
                PH_NUM2:
                begin
                    emit = 1'b1;
                    if (s1_byte_reg == BYTE_TILDE)
                        code = two_digit_key(d1_reg, d2_reg);
                    else
                        code = raw_key(d1_reg);
                end
                default:
                begin
                    // idle, and any corrupted phase acts as idle
                    if (s1_byte_reg == BYTE_ESC)
                        phase_next = PH_ESC;
                    else
                    begin
                        phase_next = PH_IDLE;
                        emit       = 1'b1;
                        code       = raw_key(s1_byte_reg);
                    end
                end
            endcase
        end

        if (emit)
        begin
            phase_next = PH_IDLE;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            d1_reg    <= '0;
            d2_reg    <= '0;
            count_reg <= '0;
        end
        else if (s1_fire)
        begin
            phase_reg <= phase_next;
            d1_reg    <= d1_next;
            d2_reg    <= d2_next;
            count_reg <= count_next;
        end
    end

    // result register
    logic             out_valid_reg, out_valid_next;
    logic [KEY_W-1:0] key_reg;

    always_comb
    begin
        if (s1_fire && emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && emit)
        begin
            key_reg <= code;
        end
    end

    assign out_valid = out_valid_reg;
    assign key_code  = key_reg;

    // plain byte in idle passes through on the next cycle
    a_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (s1_cmd_reg == CMD_BYTE) && (phase_reg == PH_IDLE) &&
         (s1_byte_reg != BYTE_ESC))
        |=> (out_valid && (key_code == raw_key($past(s1_byte_reg)))))
        else $error("idle byte did not pass through");

    // any result sends the parser back to idle with a cleared tick count
    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && emit) |=> ((phase_reg == PH_IDLE) && (count_reg == '0)))
        else $error("parser not idle after result");

    // a tick while idle changes nothing and gives no result
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (s1_cmd_reg == CMD_TICK) && (phase_reg == PH_IDLE))
        |=> ((phase_reg == PH_IDLE) && (count_reg == '0)))
        else $error("idle tick changed parser state");

    // no request is processed while a result is stalled
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !s1_fire)
        else $error("request processed over a stalled result");

    // result codes stay in range
    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (key_code <= KEY_MAX))
        else $error("key code out of range");

endmodule

FILE: tb/terminal_escape_key_decoder_checker.sv
`timescale 1ns / 1ps
module terminal_escape_key_decoder_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        command,
    input  logic [tekd_pkg::BYTE_W-1:0] byte_value,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [tekd_pkg::KEY_W-1:0]  key_code,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tekd_pkg::APB_AW-1:0] paddr,
    input  logic [tekd_pkg::APB_DW-1:0] pwdata,
    input  logic [tekd_pkg::APB_DW-1:0] prdata,
    input  logic                        pready,
    output int                          fail_count,
    output int                          keys_pending
);
    import tekd_pkg::*;

    localparam logic [BYTE_W-1:0] DIGIT0 = 8'h30;
    localparam logic [BYTE_W-1:0] DIGIT9 = 8'h39;

    // shadow of the parser state and the timeout register
    phase_t            parse_state   = PH_IDLE;
    logic [BYTE_W-1:0] lead_digit    = '0;
    logic [BYTE_W-1:0] next_digit    = '0;
    logic [TICK_W-1:0] tick_count    = '0;
    logic [TICK_W-1:0] timeout_limit = TIMEOUT_RESET;
    logic [KEY_W-1:0]  key_queue [$];
    int                mismatches    = 0;
    int                queued        = 0;

    wire [APB_DW-1:0] timeout_word = {{(APB_DW-TICK_W){1'b0}}, timeout_limit};

    assign fail_count   = mismatches;
    assign keys_pending = queued;

    // advance the shadow parser by one request, queue the key it yields
    task automatic decode_request(input logic cmd, input logic [BYTE_W-1:0] b);
        logic             hit;
        logic [KEY_W-1:0] key;
        hit = 1'b0;
        key = '0;
        if (cmd == CMD_TICK)
        begin
            if (parse_state == PH_IDLE)
                tick_count = '0;
            else
            begin
                if (tick_count != TICK_MAX)
                    tick_count = tick_count + 1'b1;
                // a zero limit resolves on the first tick like a limit of one
                if (tick_count >= timeout_limit)
                begin
                    hit = 1'b1;
                    if (parse_state == PH_NUM1 || parse_state == PH_NUM2)
                        key = raw_key(lead_digit);
                    else
                        key = KEY_ESC;
                end
            end
        end
        else
        begin
            tick_count = '0;
            case (parse_state)
                PH_ESC:
                begin
                    if (b == BYTE_CSI)
                        parse_state = PH_CSI;
                    else if (b == BYTE_SS3)
                        parse_state = PH_SS3;
                    else
                    begin
                        hit = 1'b1;
                        key = KEY_ESC;
                    end
                end
                PH_CSI:
                begin
                    if (b >= DIGIT0 && b <= DIGIT9)
                    begin
                        lead_digit  = b;
                        parse_state = PH_NUM1;
                    end
                    else
                    begin
                        hit = 1'b1;
                        case (b)
                            "A":     key = KEY_UP;
                            "B":     key = KEY_DOWN;
                            "C":     key = KEY_RIGHT;
                            "D":     key = KEY_LEFT;
                            "H":     key = KEY_HOME;
                            "F":     key = KEY_END;
                            default: key = raw_key(b);
                        endcase
                    end
                end
                PH_SS3:
                begin
                    hit = 1'b1;
                    case (b)
                        "P":     key = KEY_F1;
                        "Q":     key = KEY_F2;
                        "R":     key = KEY_F3;
                        "S":     key = KEY_F4;
                        "H":     key = KEY_HOME;
                        "F":     key = KEY_END;
                        default: key = raw_key(b);
                    endcase
                end
                PH_NUM1:
                begin
                    if (b == BYTE_TILDE)
                    begin
                        hit = 1'b1;
                        case (lead_digit)
                            "1", "7": key = KEY_HOME;
                            "3":      key = KEY_DEL;
                            "4", "8": key = KEY_END;
                            "5":      key = KEY_PGUP;
                            "6":      key = KEY_PGDN;
                            default:  key = raw_key(lead_digit);
                        endcase
                    end
                    else if (b >= DIGIT0 && b <= DIGIT9 &&
                             (lead_digit == "1" || lead_digit == "2"))
                    begin
                        next_digit  = b;
                        parse_state = PH_NUM2;
                    end
                    else
                    begin
                        hit = 1'b1;
                        key = raw_key(lead_digit);
                    end
                end
                PH_NUM2:
                begin
                    hit = 1'b1;
                    key = raw_key(lead_digit);
                    if (b == BYTE_TILDE && lead_digit == "1")
                    begin
                        case (next_digit)
                            "5":     key = KEY_F5;
                            "7":     key = KEY_F6;
                            "8":     key = KEY_F7;
                            "9":     key = KEY_F8;
                            default: key = raw_key(lead_digit);
                        endcase
                    end
                    else if (b == BYTE_TILDE && lead_digit == "2")
                    begin
                        case (next_digit)
                            "0":     key = KEY_F9;
                            "1":     key = KEY_F10;
                            "3":     key = KEY_F11;
                            "4":     key = KEY_F12;
                            default: key = raw_key(lead_digit);
                        endcase
                    end
                end
                default:
                begin
                    if (b == BYTE_ESC)
                        parse_state = PH_ESC;
                    else
                    begin
                        hit = 1'b1;
                        key = raw_key(b);
                    end
                end
            endcase
        end
        if (hit)
        begin
            key_queue.push_back(key);
            parse_state = PH_IDLE;
            tick_count  = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_state   = PH_IDLE;
            lead_digit    = '0;
            next_digit    = '0;
            tick_count    = '0;
            timeout_limit = TIMEOUT_RESET;
            key_queue.delete();
            queued        = 0;
        end
        else
        begin
            // compare each delivered key with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (key_queue.size() == 0)
                begin
                    $error("key_code unexpected: expected none, actual %0d", key_code);
                    mismatches++;
                end
                else
                begin
                    if (key_code !== key_queue[0])
                    begin
                        $error("key_code mismatch: expected %0d, actual %0d",
                               key_queue[0], key_code);
                        mismatches++;
                    end
                    void'(key_queue.pop_front());
                end
            end

            // register writes update the shadow, reads are checked against it
            if (psel && penable && pready && paddr[APB_AW-1:2] == REG_TIMEOUT)
            begin
                if (pwrite)
                    timeout_limit = pwdata[TICK_W-1:0];
                else if (prdata !== timeout_word)
                begin
                    $error("timeout_ticks mismatch: expected %0d, actual %0d",
                           timeout_word, prdata);
                    mismatches++;
                end
            end

            if (in_valid && in_ready)
                decode_request(command, byte_value);

            queued = key_queue.size();
        end
    end

endmodule

FILE: tb/terminal_escape_key_decoder_unit_tb.sv
`timescale 1ns / 1ps
module terminal_escape_key_decoder_unit_tb;
    import tekd_pkg::*;

    localparam int unsigned CLK_PERIOD    = 20;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned MAX_WAIT      = 18;
    localparam int unsigned PHASE_ITEMS   = 90;
    localparam int unsigned HOLD_AT       = 60;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned LONG_TICKS    = 30;

    localparam logic [APB_AW-1:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};
    localparam logic [BYTE_W-1:0] DIGIT0       = 8'h30;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              command;
    logic [BYTE_W-1:0] byte_value;
    logic              out_valid;
    logic              out_ready;
    logic [KEY_W-1:0]  key_code;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                chk_fails;
    int                chk_pending;

    // sender pacing and bookkeeping
    int unsigned cur_timeout = TIMEOUT_RESET;
    int unsigned sent_count  = 0;
    int unsigned n_items     = 0;
    bit          tx_calm     = 1'b0;
    bit          tx_force    = 1'b0;
    int unsigned cycle_count = 0;

    terminal_escape_key_decoder_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .byte_value (byte_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .key_code   (key_code),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    terminal_escape_key_decoder_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .byte_value   (byte_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .key_code     (key_code),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .fail_count   (chk_fails),
        .keys_pending (chk_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int unsigned draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_char(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [BYTE_W-1:0] rand_digit();
        return DIGIT0 + BYTE_W'($urandom_range(0, 9));
    endfunction

    // result side: random stalls, calm stretches and one long hold-off
    initial
    begin : receiver
        int unsigned keys_taken;
        int unsigned rx_gap;
        int unsigned rx_hold;
        bit          rx_calm;
        keys_taken = 0;
        rx_gap     = 0;
        rx_hold    = 0;
        rx_calm    = 1'b0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                keys_taken++;
                if (keys_taken % 25 == 0)
                    rx_calm = ($urandom_range(0, 2) == 0);
                rx_gap = draw_wait(rx_calm);
                if (keys_taken == HOLD_AT)
                    rx_hold = HOLD_CYCLES;
            end
            @(negedge clk);
            if (rx_hold != 0)
            begin
                out_ready <= 1'b0;
                rx_hold--;
            end
            else if (rx_gap != 0)
            begin
                out_ready <= 1'b0;
                rx_gap--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // one input request, held until accepted
    task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] b);
        int unsigned gap;
        gap = tx_force ? 0 : draw_wait(tx_calm);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        byte_value <= b;
        do @(posedge clk); while (!in_ready);
        sent_count++;
        if (sent_count % 25 == 0)
            tx_calm = ($urandom_range(0, 2) == 0);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        send_item(CMD_BYTE, b);
        n_items++;
    endtask

    // ticks carry a random byte that the block must ignore
    task automatic send_ticks(input int unsigned n, input bit pending);
        repeat (n) send_item(CMD_TICK, rand_byte());
        if (pending)
            n_items += n;
    endtask

    // sometimes let ticks pass mid-sequence, at times long enough to time out
    task automatic maybe_pause();
        int unsigned span;
        span = (cur_timeout == 0) ? 1 : cur_timeout;
        if (span > 20)
            span = 20;
        if ($urandom_range(0, 4) == 0)
            send_ticks($urandom_range(0, span + 1), 1'b1);
    endtask

    // one random escape sequence, well formed most of the time
    task automatic send_sequence();
        int unsigned       kind;
        int unsigned       depth;
        logic [BYTE_W-1:0] lead;
        kind = $urandom_range(0, 99);
        lead = ($urandom_range(0, 3) != 0) ? DIGIT0 + BYTE_W'($urandom_range(1, 2))
                                           : rand_digit();
        if (kind < 15)
            send_byte(rand_byte());
        else if (kind < 20)
            send_ticks($urandom_range(1, 3), 1'b0);
        else
        begin
            send_byte(BYTE_ESC);
            maybe_pause();
            if (kind < 32)
            begin
                // csi with a letter
                send_byte(BYTE_CSI);
                maybe_pause();
                send_byte(($urandom_range(0, 3) != 0) ? pick_char("ABCDHF")
                                                      : rand_byte());
            end
            else if (kind < 44)
            begin
                // ss3 with a letter
                send_byte(BYTE_SS3);
                maybe_pause();
                send_byte(($urandom_range(0, 3) != 0) ? pick_char("PQRSHF")
                                                      : rand_byte());
            end
            else if (kind < 58)
            begin
                // csi digit tilde
                send_byte(BYTE_CSI);
                maybe_pause();
                send_byte(rand_digit());
                maybe_pause();
                send_byte(($urandom_range(0, 7) != 0) ? BYTE_TILDE
                                                      : rand_byte());
            end
            else if (kind < 74)
            begin
                // csi digit digit tilde
                send_byte(BYTE_CSI);
                maybe_pause();
                send_byte(lead);
                maybe_pause();
                send_byte(rand_digit());
                maybe_pause();
                send_byte(($urandom_range(0, 7) != 0) ? BYTE_TILDE
                                                      : rand_byte());
            end
            else if (kind < 86)
            begin
                // broken sequence: noise after a partial prefix
                depth = $urandom_range(0, 2);
                if (depth > 0)
                    send_byte(BYTE_CSI);
                if (depth > 1)
                    send_byte(lead);
                send_byte(rand_byte());
            end
            else
            begin
                // partial prefix left to time out
                depth = $urandom_range(0, 3);
                if (depth == 1)
                    send_byte(($urandom_range(0, 1) != 0) ? BYTE_CSI : BYTE_SS3);
                if (depth > 1)
                begin
                    send_byte(BYTE_CSI);
                    send_byte(lead);
                end
                if (depth > 2)
                    send_byte(rand_digit());
                send_ticks((cur_timeout == 0) ? 1 : cur_timeout, 1'b1);
            end
        end
    endtask

    task automatic apb_access(input logic wr, input logic [TICK_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= TIMEOUT_ADDR;
        pwdata  <= {{(APB_DW-TICK_W){1'b0}}, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop sending and let every pending key come out
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (chk_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_timeout(input logic [TICK_W-1:0] value);
        wait_idle();
        apb_access(1'b1, value);
        apb_access(1'b0, '0);
        cur_timeout = value;
    endtask

    initial
    begin : stimulus
        int unsigned phase_timeouts [6];
        int unsigned start;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        command    = CMD_BYTE;
        byte_value = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // raw byte extremes and a tick while idle
        send_byte(8'h00);
        send_byte(8'hFF);
        send_ticks(1, 1'b0);
        // arrow, two-digit function key, insert has no code of its own
        send_byte(BYTE_ESC);
        send_byte(BYTE_CSI);
        send_byte("A");
        send_byte(BYTE_ESC);
        send_byte(BYTE_CSI);
        send_byte("1");
        send_byte("9");
        send_byte(BYTE_TILDE);
        send_byte(BYTE_ESC);
        send_byte(BYTE_CSI);
        send_byte("2");
        send_byte(BYTE_TILDE);
        // esc then a plain byte, esc as csi final byte
        send_byte(BYTE_ESC);
        send_byte("x");
        send_byte(BYTE_ESC);
        send_byte(BYTE_CSI);
        send_byte(BYTE_ESC);
        // a second digit after a lead other than 1 or 2 ends the sequence
        send_byte(BYTE_ESC);
        send_byte(BYTE_CSI);
        send_byte("5");
        send_byte("5");
        // zero timeout resolves on the first tick, after esc and after a digit
        set_timeout('0);
        send_byte(BYTE_ESC);
        send_ticks(1, 1'b1);
        send_byte(BYTE_ESC);
        send_byte(BYTE_CSI);
        send_byte("3");
        send_ticks(1, 1'b1);

        // random sequences under several small timeouts
        phase_timeouts    = '{1, 2, 4, 6, 9, 1};
        phase_timeouts[5] = $urandom_range(1, 12);
        foreach (phase_timeouts[i])
        begin
            set_timeout(TICK_W'(phase_timeouts[i]));
            start = n_items;
            while (n_items - start < PHASE_ITEMS)
                send_sequence();
        end

        // largest timeout: ticks well short of it keep a sequence pending
        set_timeout(TICK_MAX);
        tx_force = 1'b1;
        send_byte(BYTE_ESC);
        send_byte(BYTE_SS3);
        send_ticks(LONG_TICKS, 1'b1);
        send_byte("H");
        send_byte(BYTE_ESC);
        send_byte(BYTE_CSI);
        send_byte("1");
        send_ticks(LONG_TICKS, 1'b1);
        send_byte(BYTE_TILDE);
        tx_force = 1'b0;

        wait_idle();
        if (chk_fails == 0 && chk_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
